/* hdl/frdr_pkg.sv */
// Shared types and constants for the dielectric Fresnel reflectance pipeline.
// No dependencies; the interfaces, the top module and the bench import this package.
package frdr_pkg;

	// Field widths.
	localparam int COS_W  = 16;
	localparam int ETA_W  = 16;
	localparam int REFL_W = 16;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_OUTSIDE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ETA_INSIDE  = 1'd1;
	localparam logic [ETA_W-1:0] ETA_OUTSIDE_RST = 16'd4096;
	localparam logic [ETA_W-1:0] ETA_INSIDE_RST  = 16'd6144;

	// Internal widths.
	localparam int ROOT_W = 31;   // floor sqrt of a value below 2^62
	localparam int DIV_W  = 32;   // normalized denominators stay below 2^32
	localparam int APAR_W = 48;   // et^2 * c
	localparam int P_W    = 32;   // ei * c

	// Constants of the arithmetic.
	localparam logic [30:0] ONE_Q30    = 31'h4000_0000;
	localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
	localparam logic [63:0] ROUND_BIAS = 64'h0000_4000_0000_0000;
	localparam logic [REFL_W-1:0] REFL_MAX = 16'hFFFF;

	// Items that ride along with the square root.
	typedef struct packed {
		logic              tir;
		logic [APAR_W-1:0] a;
		logic [P_W-1:0]    p;
		logic [ETA_W-1:0]  ei;
	} sqrt_side_t;

	// Flags that ride along with the dividers.
	typedef struct packed {
		logic tir;
		logic zpar;
		logic zperp;
	} div_side_t;

endpackage

/* hdl/frdr_if.sv */
// Valid/ready channel interfaces for requests and results of the Fresnel block.
// Depends on frdr_pkg for the field widths.
interface frdr_in_if import frdr_pkg::*;;
	logic                    valid;
	logic                    ready;
	logic signed [COS_W-1:0] cos_incident;

	modport source(output valid, output cos_incident, input ready);
	modport sink(input valid, input cos_incident, output ready);
endinterface

interface frdr_out_if import frdr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [REFL_W-1:0] reflectance;
	logic              total_internal;

	modport source(output valid, output reflectance, output total_internal, input ready);
	modport sink(input valid, input reflectance, input total_internal, output ready);
endinterface

/* hdl/frdr_sqrt.sv */
// Pipelined integer square root, one result bit per register stage.
// Stand-alone; the side payload is passed through in lockstep.
module frdr_sqrt #(
	parameter int ROOT_W = 31,
	parameter int SIDE_W = 1
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic [2*ROOT_W-1:0] radicand,
	input  logic [SIDE_W-1:0]   in_side,
	output logic                out_valid,
	output logic [ROOT_W-1:0]   root,
	output logic [SIDE_W-1:0]   out_side
);
	localparam int X_W   = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 3;

	logic [X_W-1:0]    x_s    [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SIDE_W-1:0] side_s [ROOT_W];
	logic              vld_s  [ROOT_W];

	for (genvar g = 0; g < ROOT_W; g++) begin : g_stage
		logic [X_W-1:0]    x_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SIDE_W-1:0] side_in;
		logic              v_in;
		logic [REM_W-1:0]  shifted;
		logic [REM_W-1:0]  trial;
		logic              ge;

		if (g == 0) begin : g_first
			assign x_in    = radicand;
			assign rem_in  = '0;
			assign root_in = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
		end else begin : g_next
			assign x_in    = x_s[g-1];
			assign rem_in  = rem_s[g-1];
			assign root_in = root_s[g-1];
			assign side_in = side_s[g-1];
			assign v_in    = vld_s[g-1];
		end

		// Bring down the next pair of radicand bits and try the next root bit.
		assign shifted = {rem_in[REM_W-3:0], x_in[X_W-2-2*g +: 2]};
		assign trial   = {1'b0, root_in, 2'b01};
		assign ge      = (shifted >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g]    <= x_in;
				rem_s[g]  <= ge ? (shifted - trial) : shifted;
				root_s[g] <= {root_in[ROOT_W-2:0], ge};
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[ROOT_W-1];
	assign root      = root_s[ROOT_W-1];
	assign out_side  = side_s[ROOT_W-1];

endmodule

/* hdl/frdr_div.sv */
// Pipelined restoring divider: quotient = floor(num * 2^(D_W-1) / den), num <= den.
// Stand-alone; one quotient bit per register stage, side payload in lockstep.
module frdr_div #(
	parameter int D_W    = 32,
	parameter int SIDE_W = 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [D_W-1:0]    num,
	input  logic [D_W-1:0]    den,
	input  logic [SIDE_W-1:0] in_side,
	output logic              out_valid,
	output logic [D_W-1:0]    quot,
	output logic [SIDE_W-1:0] out_side
);
	logic [D_W-1:0]    den_s  [D_W];
	logic [D_W-1:0]    rem_s  [D_W];
	logic [D_W-1:0]    quot_s [D_W];
	logic [SIDE_W-1:0] side_s [D_W];
	logic              vld_s  [D_W];

	for (genvar g = 0; g < D_W; g++) begin : g_stage
		logic [D_W-1:0]    den_in;
		logic [D_W-1:0]    quot_in;
		logic [SIDE_W-1:0] side_in;
		logic              v_in;
		logic [D_W:0]      sh;
		logic [D_W:0]      diff;
		logic              ge;

		if (g == 0) begin : g_first
			assign den_in  = den;
			assign quot_in = '0;
			assign side_in = in_side;
			assign v_in    = in_valid;
			assign sh      = {1'b0, num};
		end else begin : g_next
			assign den_in  = den_s[g-1];
			assign quot_in = quot_s[g-1];
			assign side_in = side_s[g-1];
			assign v_in    = vld_s[g-1];
			assign sh      = {rem_s[g-1], 1'b0};
		end

		// Compare the partial remainder with the denominator and subtract on success.
		assign diff = sh - {1'b0, den_in};
		assign ge   = (sh >= {1'b0, den_in});

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g] <= 1'b0;
			end else if (en) begin
				vld_s[g] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g]  <= den_in;
				rem_s[g]  <= ge ? diff[D_W-1:0] : sh[D_W-1:0];
				quot_s[g] <= {quot_in[D_W-2:0], ge};
				side_s[g] <= side_in;
			end
		end
	end

	assign out_valid = vld_s[D_W-1];
	assign quot      = quot_s[D_W-1];
	assign out_side  = side_s[D_W-1];

endmodule

/* hdl/fresnel_dielectric_reflectance.sv */
// Unpolarized dielectric Fresnel reflectance, fully pipelined.
// Pipeline: 4 front stages, 31 square-root stages, 4 ratio stages,
// 32 divider stages, square and sum stages. Throughput: one request per cycle;
// a stalled output holds the whole pipeline. Reset clears all valid bits and
// loads the index registers with 1.0 (outside) and 1.5 (inside).
module fresnel_dielectric_reflectance import frdr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	frdr_in_if.sink               in_ch,
	frdr_out_if.source            out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);
	logic en;

	// Index registers.
	logic [ETA_W-1:0] eta_outside_q;
	logic [ETA_W-1:0] eta_inside_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eta_outside_q <= ETA_OUTSIDE_RST;
			eta_inside_q  <= ETA_INSIDE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ETA_OUTSIDE: eta_outside_q <= cfg_data[ETA_W-1:0];
				REG_ETA_INSIDE:  eta_inside_q  <= cfg_data[ETA_W-1:0];
				default: ;
			endcase
		end
	end

	// The whole pipeline advances unless the result register is full and held.
	logic v_s10;
	assign en           = !v_s10 || out_ch.ready;
	assign in_ch.ready  = en;

	// Stage 1: fold the cosine to its magnitude and pick the index pair.
	logic             v_s1;
	logic [15:0]      c_s1;
	logic [ETA_W-1:0] ei_s1, et_s1;
	logic [15:0]      raw;
	logic             from_inside;

	assign raw         = in_ch.cos_incident;
	assign from_inside = (raw == 16'd0) || raw[15];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1  <= from_inside ? (~raw + 16'd1) : raw;
			ei_s1 <= from_inside ? eta_inside_q : eta_outside_q;
			et_s1 <= from_inside ? eta_outside_q : eta_inside_q;
		end
	end

	// Stage 2: squares of the indices and of the cosine.
	logic             v_s2;
	logic [31:0]      ei2_s2, et2_s2, c2_s2;
	logic [15:0]      c_s2;
	logic [ETA_W-1:0] ei_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ei2_s2 <= ei_s1 * ei_s1;
			et2_s2 <= et_s1 * et_s1;
			c2_s2  <= c_s1 * c_s1;
			c_s2   <= c_s1;
			ei_s2  <= ei_s1;
		end
	end

	// Stage 3: both sides of the total internal reflection test and the cosine products.
	logic              v_s3;
	logic [61:0]       lhs_s3, rhs_s3;
	logic [APAR_W-1:0] a_s3;
	logic [P_W-1:0]    p_s3;
	logic [ETA_W-1:0]  ei_s3;
	logic [30:0]       sin2;
	logic [62:0]       lhs_full;

	assign sin2     = ONE_Q30 - c2_s2[30:0];
	assign lhs_full = ei2_s2 * sin2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lhs_s3 <= lhs_full[61:0];
			rhs_s3 <= {et2_s2, 30'd0};
			a_s3   <= et2_s2 * c_s2;
			p_s3   <= ei_s2 * c_s2;
			ei_s3  <= ei_s2;
		end
	end

	// Stage 4: compare and form the radicand et^2 cos^2 of the transmitted angle.
	logic              v_s4;
	logic              tir_s4;
	logic [61:0]       x_s4;
	logic [APAR_W-1:0] a_s4;
	logic [P_W-1:0]    p_s4;
	logic [ETA_W-1:0]  ei_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s4 <= (lhs_s3 >= rhs_s3);
			x_s4   <= rhs_s3 - lhs_s3;
			a_s4   <= a_s3;
			p_s4   <= p_s3;
			ei_s4  <= ei_s3;
		end
	end

	// Square root of the radicand.
	sqrt_side_t        sq_in_side, sq_out_side;
	logic              sq_valid;
	logic [ROOT_W-1:0] w_root;

	assign sq_in_side = '{tir: tir_s4, a: a_s4, p: p_s4, ei: ei_s4};

	frdr_sqrt #(
		.ROOT_W(ROOT_W),
		.SIDE_W($bits(sqrt_side_t))
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s4),
		.radicand (x_s4),
		.in_side  (sq_in_side),
		.out_valid(sq_valid),
		.root     (w_root),
		.out_side (sq_out_side)
	);

	// Stage 5: ei times the root.
	logic              v_s5;
	logic              tir_s5;
	logic [APAR_W-1:0] a_s5;
	logic [46:0]       b_s5;
	logic [P_W-1:0]    p_s5;
	logic [ROOT_W-1:0] w_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s5 <= sq_out_side.tir;
			a_s5   <= sq_out_side.a;
			b_s5   <= sq_out_side.ei * w_root;
			p_s5   <= sq_out_side.p;
			w_s5   <= w_root;
		end
	end

	// Stage 6: numerators and denominators of both amplitude ratios.
	logic        v_s6;
	logic        tir_s6;
	logic [48:0] npar_s6, dpar_s6;
	logic [32:0] nperp_s6, dperp_s6;
	logic [48:0] a_ext, b_ext;
	logic [32:0] p_ext, w_ext;

	assign a_ext = {1'b0, a_s5};
	assign b_ext = {2'b00, b_s5};
	assign p_ext = {1'b0, p_s5};
	assign w_ext = {2'b00, w_s5};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s6   <= tir_s5;
			npar_s6  <= (a_ext >= b_ext) ? (a_ext - b_ext) : (b_ext - a_ext);
			dpar_s6  <= a_ext + b_ext;
			nperp_s6 <= (p_ext >= w_ext) ? (p_ext - w_ext) : (w_ext - p_ext);
			dperp_s6 <= p_ext + w_ext;
		end
	end

	// Stage 7: zero tests, shift count for the parallel ratio, perpendicular shift.
	logic              v_s7;
	logic              tir_s7, zpar_s7, zperp_s7;
	logic [4:0]        kpar_s7;
	logic [48:0]       npar_s7, dpar_s7;
	logic [DIV_W-1:0]  nperp_s7, dperp_s7;
	logic [4:0]        kpar;
	logic [32:0]       nperp_sh, dperp_sh;

	always_comb begin
		kpar = 5'd0;
		for (int i = 32; i < 49; i++) begin
			if (dpar_s6[i]) begin
				kpar = 5'(i - 31);
			end
		end
	end

	assign nperp_sh = nperp_s6 >> dperp_s6[32];
	assign dperp_sh = dperp_s6 >> dperp_s6[32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s7   <= tir_s6;
			zpar_s7  <= (dpar_s6 == 49'd0);
			zperp_s7 <= (dperp_s6 == 33'd0);
			kpar_s7  <= kpar;
			npar_s7  <= npar_s6;
			dpar_s7  <= dpar_s6;
			nperp_s7 <= nperp_sh[DIV_W-1:0];
			dperp_s7 <= dperp_sh[DIV_W-1:0];
		end
	end

	// Stage 8: bring the parallel ratio below 2^32.
	logic             v_s8;
	logic             tir_s8, zpar_s8, zperp_s8;
	logic [DIV_W-1:0] npar_s8, dpar_s8, nperp_s8, dperp_s8;
	logic [48:0]      npar_sh, dpar_sh;

	assign npar_sh = npar_s7 >> kpar_s7;
	assign dpar_sh = dpar_s7 >> kpar_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s8   <= tir_s7;
			zpar_s8  <= zpar_s7;
			zperp_s8 <= zperp_s7;
			npar_s8  <= npar_sh[DIV_W-1:0];
			dpar_s8  <= dpar_sh[DIV_W-1:0];
			nperp_s8 <= nperp_s7;
			dperp_s8 <= dperp_s7;
		end
	end

	// Both ratios divided side by side.
	div_side_t        dv_in_side, dv_out_side;
	logic             dv_valid, dv_valid_perp;
	logic [DIV_W-1:0] qpar, qperp;
	logic             unused_side;

	assign dv_in_side = '{tir: tir_s8, zpar: zpar_s8, zperp: zperp_s8};

	frdr_div #(
		.D_W   (DIV_W),
		.SIDE_W($bits(div_side_t))
	) u_div_par (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (npar_s8),
		.den      (dpar_s8),
		.in_side  (dv_in_side),
		.out_valid(dv_valid),
		.quot     (qpar),
		.out_side (dv_out_side)
	);

	frdr_div #(
		.D_W   (DIV_W),
		.SIDE_W(1)
	) u_div_perp (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (v_s8),
		.num      (nperp_s8),
		.den      (dperp_s8),
		.in_side  (tir_s8),
		.out_valid(dv_valid_perp),
		.quot     (qperp),
		.out_side (unused_side)
	);

	// Stage 9: square both ratios; a zero denominator counts as one.
	logic        v_s9;
	logic        tir_s9;
	logic [63:0] sqpar_s9, sqperp_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s9    <= dv_out_side.tir;
			sqpar_s9  <= dv_out_side.zpar ? ONE_Q62 : (qpar * qpar);
			sqperp_s9 <= dv_out_side.zperp ? ONE_Q62 : (qperp * qperp);
		end
	end

	// Stage 10: average, round to Q0.16 and saturate; this is the result register.
	logic              tir_s10;
	logic [REFL_W-1:0] refl_s10;
	logic [63:0]       sum;
	logic [16:0]       rnd;

	assign sum = sqpar_s9 + sqperp_s9 + ROUND_BIAS;
	assign rnd = sum[63:47];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tir_s10  <= tir_s9;
			refl_s10 <= (tir_s9 || rnd[16]) ? REFL_MAX : rnd[REFL_W-1:0];
		end
	end

	assign out_ch.valid          = v_s10;
	assign out_ch.reflectance    = refl_s10;
	assign out_ch.total_internal = tir_s10;

	// The two dividers always carry the same requests.
	assert property (@(posedge clk) disable iff (!arst_n)
		dv_valid == dv_valid_perp && (!dv_valid || unused_side == dv_out_side.tir))
		else $error("divider lanes out of step");

	// Total internal reflection always reports full reflectance.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.total_internal |-> out_ch.reflectance == REFL_MAX)
		else $error("total internal reflection without full reflectance");

	// A stall freezes the pipeline occupancy.
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> v_s4 == $past(v_s4) && v_s9 == $past(v_s9))
		else $error("pipeline moved during a stall");

	// The input is held off exactly when a finished result is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready == (!out_ch.valid || out_ch.ready))
		else $error("input ready does not follow output backpressure");

endmodule

/* test/tb_top.sv */
// Self-checking bench for the dielectric Fresnel reflectance pipeline.
// Depends on frdr_pkg, the frdr_in_if/frdr_out_if interfaces and the block itself.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import frdr_pkg::*;

	typedef struct {
		logic [REFL_W-1:0] refl;
		logic              tir;
	} fresnel_res_t;

	// One row of the directed table; has_exp marks rows with a typed-in answer.
	typedef struct {
		logic [COS_W-1:0]  cos_v;
		bit                has_exp;
		logic [REFL_W-1:0] refl;
		logic              tir;
	} dir_row_t;

	localparam int LATENCY   = 73;
	localparam int WATCHDOG  = 4000;
	localparam int N_RANDOM  = 1900;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ETA_OUTSIDE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	frdr_in_if  in_ch();
	frdr_out_if out_ch();

	fresnel_dielectric_reflectance uut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor state: a copy of the two index registers.
	logic [ETA_W-1:0] eta_out_q = ETA_OUTSIDE_RST;
	logic [ETA_W-1:0] eta_in_q  = ETA_INSIDE_RST;

	fresnel_res_t pending_q[$];
	int  fail_cnt = 0;
	int  idle_cycles = 0;
	bit  sending_done = 1'b0;
	bit  long_hold = 1'b0;

	initial begin
		in_ch.valid = 1'b0;
		in_ch.cos_incident = '0;
		out_ch.ready = 1'b0;
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
		fail_cnt++;
	endtask

	function automatic logic [63:0] int_sqrt(input logic [63:0] x);
		logic [63:0] root;
		logic [63:0] bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x = x - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

	function automatic logic [63:0] ratio_squared(input logic [63:0] n, input logic [63:0] d);
		logic [63:0] q;
		if (d == 0) return ONE_Q62;
		while ((d >> 32) != 0) begin
			d = d >> 1;
			n = n >> 1;
		end
		q = (n << 31) / d;
		return q * q;
	endfunction

	function automatic fresnel_res_t predict_reflectance(input logic [COS_W-1:0] raw);
		fresnel_res_t res;
		logic [63:0] c, ei, et, ei2, et2, s2, lhs, rhs, w, a, b, p;
		logic [63:0] npar, dpar, nperp, dperp, sum, r;
		if (raw == 0 || raw[15]) begin
			c = (64'h10000 - 64'(raw)) & 64'hFFFF;
			if (raw == 16'h8000) c = 64'h8000;
			ei = 64'(eta_in_q);
			et = 64'(eta_out_q);
		end else begin
			c = 64'(raw);
			ei = 64'(eta_out_q);
			et = 64'(eta_in_q);
		end
		ei2 = ei * ei;
		et2 = et * et;
		s2 = (64'd1 << 30) - c * c;
		lhs = ei2 * s2;
		rhs = et2 << 30;
		if (lhs >= rhs) begin
			res.refl = REFL_MAX;
			res.tir = 1'b1;
			return res;
		end
		w = int_sqrt(rhs - lhs);
		a = et2 * c;
		b = ei * w;
		npar = (a >= b) ? a - b : b - a;
		dpar = a + b;
		p = ei * c;
		nperp = (p >= w) ? p - w : w - p;
		dperp = p + w;
		sum = ratio_squared(npar, dpar) + ratio_squared(nperp, dperp);
		r = (sum + ROUND_BIAS) >> 47;
		res.refl = (r > 65535) ? REFL_MAX : r[15:0];
		res.tir = 1'b0;
		return res;
	endfunction

	// Valid stays up between back-to-back requests and drops only for a gap.
	task automatic send_request(input logic [COS_W-1:0] v, input bit gaps);
		int gap;
		gap = gaps ? $urandom_range(0, 16) : 0;
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap != 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.cos_incident <= v;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		pending_q.push_back(predict_reflectance(v));
	endtask

	// Idle phase: drain, let the pipeline settle, then write a register.
	task automatic write_index(input logic [CFG_IDX_W-1:0] idx, input logic [ETA_W-1:0] val);
		in_ch.valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ETA_OUTSIDE) eta_out_q = val;
		else eta_in_q = val;
	endtask

	// Well-formed cosines mostly; extremes mixed in.
	function automatic logic [COS_W-1:0] random_cosine();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 8));
			3: return 16'(32'h10000 - $urandom_range(0, 8));
			default: return 16'($urandom_range(0, 16'hFFFF));
		endcase
	endfunction

	// Stimulus.
	initial begin
		dir_row_t dir_tab[$];
		logic [ETA_W-1:0] eta_sets[8][2];
		dir_row_t row;
		fresnel_res_t chk;
		int per_set;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset indices 1.0/1.5: inside at grazing gives total internal reflection.
		dir_tab = '{
			'{16'h0000, 1'b1, REFL_MAX, 1'b1},
			'{16'hFFFF, 1'b1, REFL_MAX, 1'b1},
			'{16'h0001, 1'b0, '0, 1'b0},
			'{16'h7FFF, 1'b0, '0, 1'b0},
			'{16'h8000, 1'b0, '0, 1'b0},
			'{16'h8001, 1'b0, '0, 1'b0},
			'{16'h4000, 1'b0, '0, 1'b0},
			'{16'hC000, 1'b0, '0, 1'b0},
			'{16'h5555, 1'b0, '0, 1'b0},
			'{16'hAAAA, 1'b0, '0, 1'b0},
			'{16'h2000, 1'b0, '0, 1'b0},
			'{16'hE000, 1'b0, '0, 1'b0}
		};
		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			chk = predict_reflectance(row.cos_v);
			if (row.has_exp && (chk.refl != row.refl || chk.tir != row.tir))
				report_mismatch("directed table row", i, 0);
			send_request(row.cos_v, 1'b0);
		end

		// Zero outgoing index forces total internal reflection; a zero incident index
		// near grazing follows, and grazing from inside then meets the zero outside index.
		write_index(REG_ETA_INSIDE, 16'd0);
		send_request(16'h4000, 1'b0);
		write_index(REG_ETA_INSIDE, 16'd6144);
		write_index(REG_ETA_OUTSIDE, 16'd0);
		send_request(16'h0001, 1'b0);
		send_request(16'h0000, 1'b0);

		eta_sets = '{
			'{16'd4096, 16'd6144}, '{16'd256, 16'd65535}, '{16'd65535, 16'd256},
			'{16'd65535, 16'd65535}, '{16'd256, 16'd256}, '{16'd4096, 16'd4096},
			'{16'd6144, 16'd4096}, '{16'hAAAA, 16'h5555}
		};
		per_set = N_RANDOM / 9;
		foreach (eta_sets[s]) begin
			write_index(REG_ETA_OUTSIDE, eta_sets[s][0]);
			write_index(REG_ETA_INSIDE, eta_sets[s][1]);
			repeat (per_set) send_request(random_cosine(), s % 2 == 0);
		end
		// Random indices over the full register range, back to back.
		write_index(REG_ETA_OUTSIDE, 16'($urandom_range(0, 16'hFFFF)));
		write_index(REG_ETA_INSIDE, 16'($urandom_range(0, 16'hFFFF)));
		long_hold = 1'b1;
		repeat (per_set) send_request(random_cosine(), 1'b0);
		in_ch.valid <= 1'b0;
		sending_done = 1'b1;
	end

	// Result side: random stalls, one long hold so the pipeline backs up.
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			if (long_hold) begin
				long_hold = 1'b0;
				out_ch.ready <= 1'b0;
				repeat (300) @(posedge clk);
			end
			gap = $urandom_range(0, 16);
			if ($urandom_range(0, 2) == 0) gap = 0;
			if (gap != 0) begin
				out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!out_ch.valid) @(posedge clk);
		end
	end

	// Compare accepted results with the oldest expectation.
	always @(posedge clk) begin
		fresnel_res_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (pending_q.size() == 0) begin
				report_mismatch("unexpected result", out_ch.reflectance, -1);
			end else begin
				want = pending_q.pop_front();
				if (out_ch.reflectance !== want.refl)
					report_mismatch("reflectance", out_ch.reflectance, want.refl);
				if (out_ch.total_internal !== want.tir)
					report_mismatch("total_internal", out_ch.total_internal, want.tir);
			end
		end
	end

	// Watchdog on cycles with no accepted request or result.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// End of run.
	initial begin
		@(posedge arst_n);
		while (!(sending_done && pending_q.size() == 0) && idle_cycles < WATCHDOG)
			@(posedge clk);
		if (idle_cycles >= WATCHDOG) begin
			$display("Regression FAIL");
			$finish;
		end else begin
			repeat (LATENCY + 20) @(posedge clk);
			if (fail_cnt == 0)
				$display("Regression PASS");
			else
				$display("Regression FAIL");
			$finish;
		end
	end

endmodule
